// ===== rtl/ptdp_pkg.sv =====
// Shared types and constants for the palindromic tree double palindrome block.
package ptdp_pkg;

  localparam int SYM_W = 5;
  localparam int OUT_W = 13;

  typedef struct packed {
    logic sweep;
    logic accept;
    logic txt_wr;
    logic half;
    logic x_slink;
    logic latch_now;
    logic set_suf;
    logic set_slink;
    logic set_half;
    logic set_hlink;
    logic hit_main;
    logic alloc;
    logic check;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic drop;
    logic wrap_root;
    logic walk_skip;
    logic txt_eq;
    logic hit;
    logic short_len;
  } stat_t;

endpackage

// ===== rtl/palindromic_tree_double_palindrome.sv =====
// Top level: palindromic tree with running longest double palindrome.
//
// Usage: drive symbol and first with start high; the beat is taken at an edge
// where start is high and busy is low. Each taken beat yields exactly one
// result: done is high for one cycle with best_length, text_length and
// overflow valid in that cycle. The receiver cannot stall; results must be
// taken when done is high.
// Sequence: a dropped symbol (capacity full or letter out of range) goes
// from the accepting edge straight to the result state. Otherwise each
// suffix-link walk step runs WALK_A, WALK_B and WALK_C (WALK_C is skipped
// when the position or length check fails) and each walk ends in a child
// lookup, LOOK_A, LOOK_B and LOOK_C: an item whose palindrome already exists
// takes one walk, a new node of length up to 2 takes two walks, a longer new
// node three walks, each new node then WRITE, CHK_A and CHK_B. busy stays high
// through the result cycle, so the next beat is taken in the cycle after
// done at the earliest. The registered reads of the node, text and child
// memories set these steps.
// Reset: rst (synchronous) clears control state and starts a clearing pass
// over all MAX_LEN+2 times ALPHABET child memory entries (106548 at the
// defaults), with busy high throughout; the roots are written in that pass.
module palindromic_tree_double_palindrome import ptdp_pkg::*; #(
  parameter int MAX_LEN  = 4096,
  parameter int ALPHABET = 26
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [SYM_W-1:0] symbol,
  input  logic             first,
  output logic             done,
  output logic [OUT_W-1:0] best_length,
  output logic [OUT_W-1:0] text_length,
  output logic             overflow
);

  cmd_t  cmd;
  stat_t stat;

  ptdp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  ptdp_dp #(
    .MAX_LEN  (MAX_LEN),
    .ALPHABET (ALPHABET)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .symbol      (symbol),
    .first       (first),
    .best_length (best_length),
    .text_length (text_length),
    .overflow    (overflow)
  );

endmodule

// ===== rtl/ptdp_dp.sv =====
// Datapath: node, text and child memories, walk pointers and result registers.
module ptdp_dp import ptdp_pkg::*; #(
  parameter int MAX_LEN  = 4096,
  parameter int ALPHABET = 26
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic [SYM_W-1:0] symbol,
  input  logic             first,
  output logic [OUT_W-1:0] best_length,
  output logic [OUT_W-1:0] text_length,
  output logic             overflow
);

  localparam int NODES  = MAX_LEN + 2;
  localparam int NW     = $clog2(NODES);
  localparam int TW     = $clog2(MAX_LEN + 1);
  localparam int LW     = TW + 1;
  localparam int PW     = LW + 2;
  localparam int CDEPTH = NODES * ALPHABET;
  localparam int CW     = $clog2(CDEPTH);

  logic signed [LW-1:0] nlen_mem [NODES];
  logic [NW-1:0]        slink_mem [NODES];
  logic [NW-1:0]        hlink_mem [NODES];
  logic [NW-1:0]        par_mem [NODES];
  logic [SYM_W-1:0]     let_mem [NODES];
  logic [SYM_W-1:0]     txt_mem [MAX_LEN+1];
  logic [NW-1:0]        child_mem [CDEPTH];

  logic signed [LW-1:0] nlen_rd;
  logic [NW-1:0]        slink_rd, hlink_rd, par_rd, child_rd;
  logic [SYM_W-1:0]     let_rd, txt_rd;

  logic [TW-1:0]        tc, best;
  logic [NW-1:0]        node_count, last_node, x, now, slink_now, hlink_now;
  logic [NW-1:0]        slink_new, hlink_new;
  logic signed [LW-1:0] nlen_now;
  logic [LW-1:0]        clen;
  logic [SYM_W-1:0]     c;
  logic                 ovf;
  logic [CW-1:0]        cnt;

  logic [TW-1:0]        tc_eff;
  logic                 full, okc;
  logic signed [PW-1:0] nlen_ext, pos, need;
  logic                 len_ok;
  logic [NW-1:0]        cur, base;
  logic [CW-1:0]        caddr;
  logic                 node_we;
  logic [NW-1:0]        node_wa, slink_wd, hlink_wd, par_wd;
  logic signed [LW-1:0] nlen_wd;
  logic [SYM_W-1:0]     let_wd;
  logic                 child_we;
  logic [CW-1:0]        child_wa;
  logic [NW-1:0]        child_wd;
  logic                 hit;
  logic                 dbl;

  always_comb begin
    tc_eff   = first ? '0 : tc;
    full     = tc_eff >= TW'(MAX_LEN);
    okc      = {4'b0, symbol} < 9'(ALPHABET);
    nlen_ext = {{(PW-LW){nlen_rd[LW-1]}}, nlen_rd};
    pos      = $signed({2'b0, tc}) - nlen_ext - PW'(1);
    need     = (nlen_ext + PW'(2)) <<< 1;
    len_ok   = need <= $signed({2'b0, clen});
    cur      = node_count + NW'(1);
    base     = cmd.alloc ? now : x;
    caddr    = CW'(base) * CW'(ALPHABET) + CW'(c);
    hit      = (child_rd >= NW'(2)) && (child_rd <= node_count) &&
               (par_rd == x) && (let_rd == c);
    dbl      = ({nlen_rd, 1'b0} == {1'b0, clen}) && (clen[1:0] == 2'b00) &&
               (clen > {1'b0, best});
  end

  always_comb begin
    stat.sweep_last = cnt == CW'(CDEPTH - 1);
    stat.drop       = full || !okc;
    stat.wrap_root  = nlen_rd[LW-1];
    stat.walk_skip  = (pos < PW'(1)) || (cmd.half && !len_ok);
    stat.txt_eq     = txt_rd == c;
    stat.hit        = hit;
    stat.short_len  = clen <= LW'(2);
  end

  always_comb begin
    node_we  = 1'b0;
    node_wa  = cur;
    nlen_wd  = $signed(clen);
    slink_wd = slink_new;
    hlink_wd = hlink_new;
    par_wd   = now;
    let_wd   = c;
    child_we = 1'b0;
    child_wa = caddr;
    child_wd = cur;
    if (cmd.sweep) begin
      node_we  = cnt < CW'(2);
      node_wa  = cnt[NW-1:0];
      nlen_wd  = cnt[0] ? '1 : '0;
      slink_wd = NW'(!cnt[0]);
      hlink_wd = '0;
      par_wd   = '0;
      let_wd   = '0;
      child_we = 1'b1;
      child_wa = cnt;
      child_wd = '0;
    end else if (cmd.alloc) begin
      node_we  = 1'b1;
      child_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      nlen_mem[node_wa]  <= nlen_wd;
      slink_mem[node_wa] <= slink_wd;
      hlink_mem[node_wa] <= hlink_wd;
      par_mem[node_wa]   <= par_wd;
      let_mem[node_wa]   <= let_wd;
    end
    nlen_rd  <= nlen_mem[x];
    slink_rd <= slink_mem[x];
    hlink_rd <= hlink_mem[x];
    par_rd   <= par_mem[child_rd];
    let_rd   <= let_mem[child_rd];
  end

  always_ff @(posedge clk) begin
    if (cmd.txt_wr) begin
      txt_mem[tc] <= c;
    end
    txt_rd <= txt_mem[pos[TW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (child_we) begin
      child_mem[child_wa] <= child_wd;
    end
    child_rd <= child_mem[caddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      c <= symbol;
      x <= first ? '0 : last_node;
    end else if (cmd.x_slink) begin
      x <= slink_rd;
    end else if (cmd.set_suf) begin
      x <= slink_now;
    end else if (cmd.set_half) begin
      x <= hlink_now;
    end else if (cmd.alloc) begin
      x <= hlink_new;
    end
    if (cmd.latch_now) begin
      now       <= x;
      nlen_now  <= nlen_rd;
      slink_now <= slink_rd;
      hlink_now <= hlink_rd;
    end
    if (cmd.set_suf) begin
      clen <= LW'(nlen_now + LW'(2));
    end
    if (cmd.set_slink) begin
      slink_new <= hit ? child_rd : '0;
      hlink_new <= hit ? child_rd : '0;
    end
    if (cmd.set_hlink) begin
      hlink_new <= hit ? child_rd : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tc         <= '0;
      best       <= '0;
      node_count <= NW'(1);
      last_node  <= '0;
      ovf        <= 1'b0;
      cnt        <= '0;
    end else begin
      if (cmd.sweep) begin
        cnt <= cnt + CW'(1);
      end
      if (cmd.accept) begin
        ovf <= full;
        tc  <= tc_eff + TW'(!full && okc);
        if (first) begin
          best       <= '0;
          node_count <= NW'(1);
          last_node  <= '0;
        end
      end
      if (cmd.hit_main) begin
        last_node <= child_rd;
      end
      if (cmd.alloc) begin
        node_count <= cur;
        last_node  <= cur;
      end
      if (cmd.check && dbl) begin
        best <= clen[TW-1:0];
      end
    end
  end

  assign best_length = OUT_W'(best);
  assign text_length = OUT_W'(tc);
  assign overflow    = ovf;

  a_nodes_bounded: assert property (@(posedge clk) disable iff (rst)
    int'(node_count) <= int'(tc) + 1)
    else $error("node count exceeds text length plus one");

  a_last_allocated: assert property (@(posedge clk) disable iff (rst)
    last_node <= node_count)
    else $error("last node beyond allocated nodes");

  a_best_mult4: assert property (@(posedge clk) disable iff (rst)
    best[1:0] == 2'b00)
    else $error("best length not a multiple of four");

  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |=> node_count == $past(node_count) + NW'(1))
    else $error("allocation did not advance node count");

endmodule

// ===== rtl/ptdp_ctrl.sv =====
// Controller: sequences clearing sweep, suffix link walks, child lookups and allocation.
module ptdp_ctrl import ptdp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  done
);

  typedef enum logic [12:0] {
    SWEEP  = 13'b0000000000001,
    IDLE   = 13'b0000000000010,
    START  = 13'b0000000000100,
    WALK_A = 13'b0000000001000,
    WALK_B = 13'b0000000010000,
    WALK_C = 13'b0000000100000,
    LOOK_A = 13'b0000001000000,
    LOOK_B = 13'b0000010000000,
    LOOK_C = 13'b0000100000000,
    WRITE  = 13'b0001000000000,
    CHK_A  = 13'b0010000000000,
    CHK_B  = 13'b0100000000000,
    RESULT = 13'b1000000000000
  } state_t;

  typedef enum logic [2:0] {
    PH_MAIN = 3'b001,
    PH_SUF  = 3'b010,
    PH_HALF = 3'b100
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    cmd.half   = phase == PH_HALF;
    case (state)
      SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) state_next = IDLE;
      end
      IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = stat.drop ? RESULT : START;
        end
      end
      START: begin
        cmd.txt_wr = 1'b1;
        phase_next = PH_MAIN;
        state_next = WALK_A;
      end
      WALK_A: state_next = WALK_B;
      WALK_B: begin
        if (stat.wrap_root) begin
          state_next = LOOK_A;
        end else if (stat.walk_skip) begin
          cmd.x_slink = 1'b1;
          state_next  = WALK_A;
        end else begin
          state_next = WALK_C;
        end
      end
      WALK_C: begin
        if (stat.txt_eq) begin
          state_next = LOOK_A;
        end else begin
          cmd.x_slink = 1'b1;
          state_next  = WALK_A;
        end
      end
      LOOK_A: begin
        cmd.latch_now = phase == PH_MAIN;
        state_next    = LOOK_B;
      end
      LOOK_B: state_next = LOOK_C;
      LOOK_C: begin
        case (phase)
          PH_MAIN: begin
            if (stat.hit) begin
              cmd.hit_main = 1'b1;
              state_next   = RESULT;
            end else begin
              cmd.set_suf = 1'b1;
              phase_next  = PH_SUF;
              state_next  = WALK_A;
            end
          end
          PH_SUF: begin
            cmd.set_slink = 1'b1;
            if (stat.short_len) begin
              state_next = WRITE;
            end else begin
              cmd.set_half = 1'b1;
              phase_next   = PH_HALF;
              state_next   = WALK_A;
            end
          end
          default: begin
            cmd.set_hlink = 1'b1;
            state_next    = WRITE;
          end
        endcase
      end
      WRITE: begin
        cmd.alloc  = 1'b1;
        state_next = CHK_A;
      end
      CHK_A: state_next = CHK_B;
      CHK_B: begin
        cmd.check  = 1'b1;
        state_next = RESULT;
      end
      RESULT: state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SWEEP;
      phase <= PH_MAIN;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  assign busy = state != IDLE;
  assign done = state == RESULT;

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_drop_quick: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && stat.drop) |=> done)
    else $error("dropped symbol did not report at once");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> state == IDLE)
    else $error("item taken while busy");

endmodule
